// ===== rtl/rpi_pkg.sv =====
// Shared types and constants for the RGB palette indexer.
// Used by rpi_ctrl, rpi_datapath and rgb_palette_indexer; depends on nothing.
`timescale 1ns / 1ps

package rpi_pkg;

  // Default palette depth and the fixed field widths of the pixel stream.
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int ChanW               = 8;
  localparam int ColorW              = 3 * ChanW;
  localparam int IndexW              = 8;
  localparam int UsedW               = 9;

  // One incoming pixel request.
  typedef struct packed {
    logic             start_of_image;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // One outgoing result request.
  typedef struct packed {
    logic [IndexW-1:0] color_index;
    logic              new_entry;
    logic              palette_miss;
    logic [UsedW-1:0]  palette_used;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_en;
    logic load_result;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_end;
  } dp_status_t;

endpackage

// ===== rtl/rpi_ctrl.sv =====
// Controller of the RGB palette indexer: request handshakes and scan sequencing.
// Depends on rpi_pkg for the command and status types.
`timescale 1ns / 1ps

module rpi_ctrl import rpi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_q, state_d;
  logic out_vld_q, out_vld_d;
  logic done;
  logic slot_free;

  // The search is over once a match turns up or every filled entry was compared.
  assign done      = status_i.hit || status_i.scan_end;
  assign slot_free = !out_vld_q || out_ready_i;

  // Commands to the datapath.
  always_comb begin
    cmd_o.accept      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan_en     = (state_q == S_SCAN) && !done;
    cmd_o.load_result = (state_q == S_SCAN) && done && slot_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_o.load_result) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // The output register is full from a load until the receiver takes it.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load_result) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

  // A result is only loaded while the output register is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> (!out_vld_q || out_ready_i))
    else $error("result loaded over an untaken result");

  // An accepted pixel always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_SCAN) && !out_vld_q || (state_q == S_SCAN))
    else $error("accepted pixel did not start a scan");

  // Every finished scan leaves a waiting result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |=> out_vld_q && (state_q == S_IDLE))
    else $error("finished scan left no result");

endmodule

// ===== rtl/rpi_datapath.sv =====
// Datapath of the RGB palette indexer: palette memory, scan pointer, compare and result register.
// Depends on rpi_pkg for the payload, command and status types.
`timescale 1ns / 1ps

module rpi_datapath import rpi_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pixel_t     pixel_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output result_t    result_o
);

  localparam int IdxW = $clog2(PALETTE_ENTRIES);
  localparam int CntW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(PALETTE_ENTRIES);

  logic [ColorW-1:0] mem [PALETTE_ENTRIES];

  logic [ColorW-1:0] pix_q;
  logic [CntW-1:0]   used_q;
  logic [CntW-1:0]   addr_q;
  logic              cmp_vld_q;
  logic [ColorW-1:0] rd_data_q;
  logic [IdxW-1:0]   cmp_idx_q;
  result_t           res_q;

  logic              more;
  logic              issue;
  logic              not_full;
  logic [IdxW-1:0]   idx_sel;
  logic              added;
  logic              miss;
  logic [CntW-1:0]   used_next;
  logic [IdxW+7:0]   idx_ext;
  logic [CntW+8:0]   used_ext;
  logic              wr_en;

  // A read is issued for each filled entry in turn; its compare follows in the next cycle.
  assign more  = addr_q < used_q;
  assign issue = cmd_i.scan_en && more;

  assign status_o.hit      = cmp_vld_q && (rd_data_q == pix_q);
  assign status_o.scan_end = !cmp_vld_q && !more;

  // Result of the finished scan: match, insertion at the next free index, or miss.
  always_comb begin
    not_full  = (used_q != FullCnt);
    idx_sel   = '0;
    added     = 1'b0;
    miss      = 1'b0;
    used_next = used_q;
    if (status_o.hit) begin
      idx_sel = cmp_idx_q;
    end else if (not_full) begin
      idx_sel   = used_q[IdxW-1:0];
      added     = 1'b1;
      used_next = CntW'(used_q + 1'b1);
    end else begin
      miss = 1'b1;
    end
  end

  assign idx_ext  = {8'b0, idx_sel};
  assign used_ext = {9'b0, used_next};
  assign wr_en    = cmd_i.load_result && added;

  // Palette memory with a registered read port and one write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[used_q[IdxW-1:0]] <= pix_q;
    end
    if (issue) begin
      rd_data_q <= mem[addr_q[IdxW-1:0]];
      cmp_idx_q <= addr_q[IdxW-1:0];
    end
  end

  // Pixel capture and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= {pixel_i.red, pixel_i.green, pixel_i.blue};
    end
    if (cmd_i.load_result) begin
      res_q.color_index  <= idx_ext[IndexW-1:0];
      res_q.new_entry    <= added;
      res_q.palette_miss <= miss;
      res_q.palette_used <= used_ext[UsedW-1:0];
    end
  end

  // Fill count, scan pointer and compare valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (pixel_i.start_of_image) begin
          used_q <= '0;
        end
        addr_q    <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_en) begin
        cmp_vld_q <= more;
        if (more) begin
          addr_q <= CntW'(addr_q + 1'b1);
        end
      end
      if (cmd_i.load_result) begin
        used_q <= used_next;
      end
    end
  end

  assign result_o = res_q;

  // The fill count never passes the palette depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= FullCnt)
    else $error("palette fill count beyond depth");

  // A compare only ever looks at an entry below the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> ({1'b0, cmp_idx_q} < (IdxW + 1)'(used_q)))
    else $error("compare of an unfilled palette entry");

endmodule

// ===== rtl/rgb_palette_indexer.sv =====
// RGB palette indexer, top level: joins the controller and the datapath.
// Depends on rpi_pkg, rpi_ctrl and rpi_datapath.
`timescale 1ns / 1ps

// Usage:
// A pixel request (start_of_image, red, green, blue) enters on in_valid_i /
// in_ready_o; its result (color_index, new_entry, palette_miss, palette_used)
// leaves on out_valid_o / out_ready_i. Colours join the palette in order of
// first appearance; a new colour is flagged new_entry, and once the palette is
// full an unknown colour gives index 0 with palette_miss set. start_of_image
// empties the palette before its pixel is handled.
// Timing: the palette memory is read one entry a cycle, so the search time of a
// pixel grows with the index of its colour, and a new or missing colour is
// compared against every filled entry. The next pixel is accepted only once
// the result of the last one is loaded; the single memory read port and the
// linear scan set the time per pixel.
// A finished result waits in the output register while the next pixel is
// accepted and searched; a stalled receiver holds the block only once the next
// result is also ready. Reset empties the palette and clears both handshakes;
// no clearing pass is needed.
module rgb_palette_indexer import rpi_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  pixel_t  in_pixel_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rpi_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (in_pixel_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_result_o)
  );

endmodule
